// ===== src/lbs_pkg.sv =====
package lbs_pkg;

    localparam int NUM_JOINTS      = 32;
    localparam int ELEMS_PER_JOINT = 12;
    localparam int TABLE_DEPTH     = NUM_JOINTS * ELEMS_PER_JOINT;
    localparam int ADDR_W          = $clog2(TABLE_DEPTH);
    localparam int JOINT_W         = 5;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [15:0] TOL_RESET  = 16'd33;
    localparam logic [19:0] WEIGHT_ONE = 20'd32768;
    localparam logic [19:0] WTOT_MAX   = 20'hFFFFF;

    typedef enum logic {
        CMD_LOAD      = 1'b0,
        CMD_INFLUENCE = 1'b1
    } command_t;

    typedef struct packed {
        logic               command;
        logic [4:0]         joint_index;
        logic [3:0]         element_index;
        logic signed [31:0] element_value;
        logic signed [31:0] rest_x;
        logic signed [31:0] rest_y;
        logic signed [31:0] rest_z;
        logic [15:0]        weight;
        logic               last_influence;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
        logic               weight_sum_error;
    } out_item_t;

    // Classified work handed from the front part to the back part.
    // For a load, base holds the table address and rest_x the element value.
    typedef struct packed {
        command_t           command;
        logic               valid_joint;
        logic [ADDR_W-1:0]  base;
        logic signed [31:0] rest_x;
        logic signed [31:0] rest_y;
        logic signed [31:0] rest_z;
        logic [15:0]        weight;
        logic               last_influence;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_SUM,
        ST_SCALE,
        ST_ACC,
        ST_EMIT
    } back_state_t;

endpackage

// ===== src/lbs_front.sv =====
module lbs_front (
    input  logic              push,
    output logic              full,
    input  lbs_pkg::in_item_t in_item,
    output logic              job_push,
    output lbs_pkg::job_t     job,
    input  logic              job_full
);
    import lbs_pkg::*;

    logic               is_load;
    logic               joint_ok;
    logic               elem_ok;
    logic [ADDR_W-1:0]  base;

    assign full     = job_full;
    assign is_load  = (command_t'(in_item.command) == CMD_LOAD);
    assign joint_ok = ({1'b0, in_item.joint_index} < (JOINT_W + 1)'(NUM_JOINTS));
    assign elem_ok  = (in_item.element_index < 4'(ELEMS_PER_JOINT));
    assign base     = ADDR_W'(in_item.joint_index) * ADDR_W'(ELEMS_PER_JOINT);

    assign job_push           = push && !job_full;
    assign job.command        = command_t'(in_item.command);
    assign job.valid_joint    = is_load ? (joint_ok && elem_ok) : joint_ok;
    assign job.base           = is_load ? (base + ADDR_W'(in_item.element_index)) : base;
    assign job.rest_x         = is_load ? in_item.element_value : in_item.rest_x;
    assign job.rest_y         = in_item.rest_y;
    assign job.rest_z         = in_item.rest_z;
    assign job.weight         = in_item.weight;
    assign job.last_influence = in_item.last_influence;

endmodule

// ===== src/lbs_queue.sv =====
module lbs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  lbs_pkg::job_t wdata,
    output logic          full,
    input  logic          rd,
    output lbs_pkg::job_t rdata,
    output logic          empty
);
    import lbs_pkg::*;

    job_t       mem_reg [QUEUE_DEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'(QUEUE_DEPTH));
    assign empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg + 1'b1;
        rp_next  = rp_reg + 1'b1;
        cnt_next = cnt_reg + 2'(wr && !full) - 2'(rd && !empty);
    end

    always_ff @(posedge clk)
    begin
        if (wr && !full)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr && !full)
            begin
                wp_reg <= wp_next;
            end
            if (rd && !empty)
            begin
                rp_reg <= rp_next;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/lbs_back.sv =====
module lbs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_data,
    input  logic              job_empty,
    input  lbs_pkg::job_t     job,
    output logic              job_pop,
    output logic              empty,
    input  logic              pop,
    output lbs_pkg::out_item_t out_item
);
    import lbs_pkg::*;

    logic signed [31:0] table_mem [TABLE_DEPTH];
    logic signed [31:0] rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;

    back_state_t        state_reg, state_next;
    logic [1:0]         row_reg, row_next;
    logic [2:0]         col_reg, col_next;
    job_t               job_reg;
    logic               load_job;

    logic signed [63:0] prod_reg;
    logic signed [49:0] t_reg;
    logic signed [47:0] t_sat_reg;
    logic signed [63:0] contrib_reg;
    logic signed [63:0] sum_reg [3];
    logic [19:0]        wtot_reg;
    logic [15:0]        tol_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic signed [31:0] vsel;
    logic signed [63:0] rnd;
    logic signed [64:0] wide;
    logic signed [64:0] acc_sum;
    logic [20:0]        wsum;
    logic [19:0]        wtot_new;
    logic [19:0]        diff;
    logic signed [63:0] scaled;

    always_ff @(posedge clk)
    begin
        if (load_job && (job.command == CMD_LOAD) && job.valid_joint)
        begin
            table_mem[job.base] <= job.rest_x;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    always_comb
    begin
        vsel = (col_reg == 3'd0) ? job_reg.rest_x :
               (col_reg == 3'd1) ? job_reg.rest_y : job_reg.rest_z;
    end

    assign rnd     = (prod_reg + 64'sd32768) >>> 16;
    assign scaled  = (64'(t_sat_reg) * $signed({48'd0, job_reg.weight})
                      + 64'sd16384) >>> 15;
    assign wide    = 65'(sum_reg[row_reg]) + 65'(contrib_reg);
    assign acc_sum = (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF) ? 65'sh0_7FFF_FFFF_FFFF_FFFF :
                     (wide < -65'sh0_8000_0000_0000_0000) ? -65'sh0_8000_0000_0000_0000 :
                     wide;
    assign wsum     = {1'b0, wtot_reg} + 21'(job.weight);
    assign wtot_new = wsum[20] ? WTOT_MAX : wsum[19:0];
    assign diff     = (wtot_reg >= WEIGHT_ONE) ? wtot_reg - WEIGHT_ONE
                                               : WEIGHT_ONE - wtot_reg;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    assign load_job = (state_reg == ST_IDLE) && !job_empty && !out_valid_reg;
    assign job_pop  = load_job;
    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        rd_addr    = job_reg.base + ADDR_W'({row_reg, 2'b00}) + ADDR_W'(col_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr  = job.base;
                row_next = 2'd0;
                col_next = 3'd0;
                if (load_job && (job.command == CMD_INFLUENCE))
                begin
                    state_next = job.valid_joint ? ST_ROW
                               : (job.last_influence ? ST_EMIT : ST_IDLE);
                end
            end
            ST_ROW:
            begin
                col_next = col_reg + 3'd1;
                rd_addr  = job_reg.base + ADDR_W'({row_reg, 2'b00}) + ADDR_W'(col_next);
                if (col_reg == 3'd3)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_ACC;
            ST_ACC:
            begin
                col_next = 3'd0;
                row_next = row_reg + 2'd1;
                rd_addr  = job_reg.base + ADDR_W'({row_next, 2'b00});
                if (row_reg == 2'd2)
                begin
                    state_next = job_reg.last_influence ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    state_next = ST_ROW;
                end
            end
            ST_EMIT:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_job)
        begin
            job_reg <= job;
        end
        if (state_reg == ST_ROW)
        begin
            prod_reg <= 64'(rd_data_reg) * 64'(vsel);
        end
        if (state_reg == ST_SUM)
        begin
            t_sat_reg <= (t_reg > 50'sh0_7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF :
                         (t_reg < -50'sh0_8000_0000_0000) ? 48'sh8000_0000_0000 :
                         t_reg[47:0];
        end
        if (state_reg == ST_SCALE)
        begin
            contrib_reg <= scaled;
        end
    end

    // The row sum adds each of three rounded products in the next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= 2'd0;
            col_reg       <= 3'd0;
            t_reg         <= '0;
            sum_reg[0]    <= '0;
            sum_reg[1]    <= '0;
            sum_reg[2]    <= '0;
            wtot_reg      <= '0;
            tol_reg       <= TOL_RESET;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_data;
            end
            if (state_reg == ST_ROW)
            begin
                if (col_reg == 3'd0)
                begin
                    t_reg <= '0;
                end
                else if (col_reg == 3'd3)
                begin
                    t_reg <= t_reg + 50'(rnd) + 50'(rd_data_reg);
                end
                else
                begin
                    t_reg <= t_reg + 50'(rnd);
                end
            end
            if (state_reg == ST_ACC)
            begin
                sum_reg[row_reg] <= acc_sum[63:0];
            end
            if (load_job && (job.command == CMD_INFLUENCE))
            begin
                wtot_reg <= wtot_new;
            end
            if (state_reg == ST_EMIT)
            begin
                out_valid_reg            <= 1'b1;
                out_reg.new_x            <= sat32(sum_reg[0]);
                out_reg.new_y            <= sat32(sum_reg[1]);
                out_reg.new_z            <= sat32(sum_reg[2]);
                out_reg.weight_sum_error <= (diff > 20'(tol_reg));
                sum_reg[0]               <= '0;
                sum_reg[1]               <= '0;
                sum_reg[2]               <= '0;
                wtot_reg                 <= '0;
            end
            else if (out_valid_reg && pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== src/linear_blend_skinning_top.sv =====
// Channel   Handshake        Payload
// input     push / full      in_item  (lbs_pkg::in_item_t)
// result    empty / pop      out_item (lbs_pkg::out_item_t)
// config    cfg_we           cfg_data (weight tolerance)
//
// Every item passes the two-entry queue; a valid load goes into the table as the back part takes it.
// An influence is taken from the queue in the idle state, then each of three matrix rows goes
// through four table reads, row sum, weight scale and accumulate.
// The last influence of a vertex adds an emit state that registers the result.
// Reset clears sums, weight total and the queue; the transform table is not cleared.
// A pending result blocks the back part, and the two-entry queue then fills.
module linear_blend_skinning_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  lbs_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output lbs_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data
);
    import lbs_pkg::*;

    logic              job_push, job_full, job_pop, job_empty;
    job_t              job_in, job_out;

    lbs_front u_front (
        .push(push), .full(full), .in_item(in_item),
        .job_push(job_push), .job(job_in), .job_full(job_full)
    );

    lbs_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr(job_push), .wdata(job_in), .full(job_full),
        .rd(job_pop), .rdata(job_out), .empty(job_empty)
    );

    lbs_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .job_empty(job_empty), .job(job_out), .job_pop(job_pop),
        .empty(empty), .pop(pop), .out_item(out_item)
    );

endmodule

// ===== dv/tb_linear_blend_skinning_top.sv =====
`timescale 1ns / 100ps

module tb_linear_blend_skinning_top;
    import lbs_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 40;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    in_item_t in_item;
    logic empty;
    logic pop;
    out_item_t out_item;
    logic cfg_we;
    logic [15:0] cfg_data;

    logic signed [31:0] xform[TABLE_DEPTH];
    bit [11:0] loaded_mask[NUM_JOINTS];
    logic signed [63:0] acc_x;
    logic signed [63:0] acc_y;
    logic signed [63:0] acc_z;
    logic [19:0] weight_acc;
    logic [15:0] tolerance;

    out_item_t vertex_q[$];
    int errors;
    int vertices_checked;
    int items_sent;
    int cycles;
    int hold_cycles;
    bit idle_on;

    linear_blend_skinning_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .in_item(in_item),
        .empty(empty),
        .pop(pop),
        .out_item(out_item),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic signed [63:0] blend_row(int base, in_item_t it);
        logic signed [63:0] t;
        logic signed [63:0] m;
        logic signed [63:0] v;
        logic signed [63:0] w;
        t = 0;
        for (int c = 0; c < 3; c++)
        begin
            m = xform[base + c];
            v = (c == 0) ? it.rest_x : (c == 1) ? it.rest_y : it.rest_z;
            t = t + ((m * v + 64'sd32768) >>> 16);
        end
        m = xform[base + 3];
        t = t + m;
        if (t > 64'sh7FFF_FFFF_FFFF)
            t = 64'sh7FFF_FFFF_FFFF;
        if (t < -64'sh8000_0000_0000)
            t = -64'sh8000_0000_0000;
        w = {48'd0, it.weight};
        return (t * w + 64'sd16384) >>> 15;
    endfunction

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < -65'sh0_8000_0000_0000_0000)
            return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    task automatic skin_predict(in_item_t it);
        out_item_t r;
        int base;
        int diff;
        logic [20:0] wsum;
        if (it.command == CMD_LOAD)
        begin
            if (it.element_index < ELEMS_PER_JOINT)
            begin
                xform[it.joint_index * ELEMS_PER_JOINT + it.element_index] = it.element_value;
                loaded_mask[it.joint_index][it.element_index] = 1'b1;
            end
            return;
        end
        base = it.joint_index * ELEMS_PER_JOINT;
        acc_x = sat_add(acc_x, blend_row(base, it));
        acc_y = sat_add(acc_y, blend_row(base + 4, it));
        acc_z = sat_add(acc_z, blend_row(base + 8, it));
        wsum = 21'(weight_acc) + 21'(it.weight);
        weight_acc = (wsum > 21'(WTOT_MAX)) ? WTOT_MAX : wsum[19:0];
        if (!it.last_influence)
            return;
        diff = int'(weight_acc) - int'(WEIGHT_ONE);
        if (diff < 0)
            diff = -diff;
        r.new_x = clamp32(acc_x);
        r.new_y = clamp32(acc_y);
        r.new_z = clamp32(acc_z);
        r.weight_sum_error = (diff > int'(tolerance));
        vertex_q = {vertex_q, r};
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        weight_acc = 0;
    endtask

    task automatic send_item(in_item_t it);
        if (idle_on && $urandom_range(99) < 28)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        push <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (full);
        skin_predict(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (vertex_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_tolerance(logic [15:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        tolerance = value;
    endtask

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic in_item_t load_item(int j, int e, logic signed [31:0] val);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.command = CMD_LOAD;
        it.joint_index = 5'(j);
        it.element_index = 4'(e);
        it.element_value = val;
        return it;
    endfunction

    function automatic in_item_t influence_item(int j, logic [15:0] w, bit last);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.command = CMD_INFLUENCE;
        it.joint_index = 5'(j);
        it.rest_x = rand_q();
        it.rest_y = rand_q();
        it.rest_z = rand_q();
        it.weight = w;
        it.last_influence = last;
        return it;
    endfunction

    function automatic int pick_joint();
        int j;
        do
            j = $urandom_range(NUM_JOINTS - 1);
        while (loaded_mask[j] != 12'hFFF);
        return j;
    endfunction

    task automatic send_vertex(int n);
        int left;
        logic [15:0] w;
        left = 32768;
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                w = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 32768)) : 16'(left);
            else
                w = 16'($urandom_range(0, left));
            left = left - int'(w);
            if (left < 0)
                left = 0;
            if ($urandom_range(9) == 0)
                w = 16'(int'(w) + int'($urandom_range(0, 80)) - 40);
            send_item(influence_item(pick_joint(), w, i == n - 1));
        end
    endtask

    task automatic test_directed();
        for (int j = 0; j < 2; j++)
            for (int e = 0; e < ELEMS_PER_JOINT; e++)
                send_item(load_item(j, e, (e % 5 == 0) ? 32'sh0001_0000 : 32'sh0));
        send_item(load_item(0, 13, 32'sh1234_5678));
        send_item(load_item(1, 15, 32'sh8000_0000));
        send_item(load_item(31, 12, 32'sh7FFF_FFFF));
        send_item(influence_item(0, 16'd32768, 1'b1));
        send_item(influence_item(1, 16'd0, 1'b1));
        send_item(influence_item(0, 16'd16384, 1'b0));
        send_item(influence_item(1, 16'd16384, 1'b1));
        send_item(influence_item(0, 16'd32768, 1'b0));
        send_item(influence_item(1, 16'd32768, 1'b1));
        send_item(load_item(1, 3, 32'sh7FFF_FFFF));
        send_item(load_item(1, 0, 32'sh8000_0000));
        send_item(influence_item(1, 16'hFFFF, 1'b0));
        send_item(influence_item(1, 16'hFFFF, 1'b1));
        send_item(influence_item(0, 16'd32768 + 16'd33, 1'b1));
        send_item(influence_item(0, 16'd32768 + 16'd34, 1'b1));
    endtask

    task automatic test_config();
        logic [15:0] settings[4];
        settings = '{16'd0, 16'd32768, 16'd1, 16'($urandom_range(0, 32768))};
        foreach (settings[k])
        begin
            write_tolerance(settings[k]);
            for (int i = 0; i < 6; i++)
                send_vertex($urandom_range(1, 3));
        end
        write_tolerance(TOL_RESET);
    endtask

    task automatic test_random();
        int n;
        for (int i = 0; i < 535; i++)
        begin
            idle_on = !(i >= 150 && i < 230);
            if ($urandom_range(3) == 0 || loaded_mask[1] != 12'hFFF)
                send_item(load_item($urandom_range(NUM_JOINTS - 1),
                                    $urandom_range(15), rand_q()));
            else if ($urandom_range(9) == 0)
                send_item(influence_item(pick_joint(), 16'($urandom), $urandom_range(1)));
            else
            begin
                n = $urandom_range(1, 4);
                send_vertex(n);
                i = i + n - 1;
            end
        end
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 8; i++)
            send_vertex(2);
        wait_drained();
        for (int i = 0; i < 6; i++)
            send_vertex($urandom_range(1, 3));
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end
        else
            pop <= !idle_on || ($urandom_range(99) >= 28);
    end

    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && pop && !empty)
        begin
            if (vertex_q.size() == 0)
            begin
                $display("%0t: unexpected result x=%h y=%h z=%h err=%b", $time,
                         out_item.new_x, out_item.new_y, out_item.new_z,
                         out_item.weight_sum_error);
                errors++;
            end
            else
            begin
                exp_r = vertex_q.pop_front();
                vertices_checked++;
                if (out_item.new_x !== exp_r.new_x)
                begin
                    $display("%0t: new_x expected %h actual %h", $time, exp_r.new_x, out_item.new_x);
                    errors++;
                end
                if (out_item.new_y !== exp_r.new_y)
                begin
                    $display("%0t: new_y expected %h actual %h", $time, exp_r.new_y, out_item.new_y);
                    errors++;
                end
                if (out_item.new_z !== exp_r.new_z)
                begin
                    $display("%0t: new_z expected %h actual %h", $time, exp_r.new_z, out_item.new_z);
                    errors++;
                end
                if (out_item.weight_sum_error !== exp_r.weight_sum_error)
                begin
                    $display("%0t: weight_sum_error expected %b actual %b", $time,
                             exp_r.weight_sum_error, out_item.weight_sum_error);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        errors = 0;
        vertices_checked = 0;
        items_sent = 0;
        cycles = 0;
        hold_cycles = 0;
        idle_on = 1'b1;
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        weight_acc = 0;
        tolerance = TOL_RESET;
        foreach (loaded_mask[j])
            loaded_mask[j] = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_config();
        test_random();
        test_backpressure();
        wait_drained();
        $display("Sent %0d items and checked %0d skinned vertices, including", items_sent,
                 vertices_checked);
        $display("tolerance changes, ignored loads, saturation and a long output stall.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
